// ----- src/bgh_pkg.sv -----
// Battery gauge package: shared types, level and divider-select codes, discharge curve.
// No dependencies; used by every module of the gauge.
`default_nettype none
package bgh_pkg;

   localparam int CURVE_MAX = 16;
   localparam int DIV_W     = 24;
   localparam int DEN_W     = 13;

   localparam logic [11:0] RAW_FULL = 12'd4095;

   localparam logic [1:0] LVL_NORMAL   = 2'd0;
   localparam logic [1:0] LVL_LOW      = 2'd1;
   localparam logic [1:0] LVL_CRIT     = 2'd2;
   localparam logic [1:0] LVL_CHARGING = 2'd3;

   localparam logic [1:0] DSEL_AVG = 2'd0;
   localparam logic [1:0] DSEL_PCT = 2'd2;

   localparam logic [2:0] REG_LOW_ENTER  = 3'd0;
   localparam logic [2:0] REG_LOW_EXIT   = 3'd1;
   localparam logic [2:0] REG_CRIT_ENTER = 3'd2;
   localparam logic [2:0] REG_CRIT_EXIT  = 3'd3;
   localparam logic [2:0] REG_CHARGING   = 3'd4;
   localparam logic [2:0] REG_ADC_REF    = 3'd5;

   // LiPo discharge curve, highest voltage first; tail repeats the last point
   localparam logic [12:0] CURVE_MV [CURVE_MAX] = '{
      13'd4200, 13'd4150, 13'd4100, 13'd4050, 13'd4000, 13'd3950, 13'd3900, 13'd3850,
      13'd3800, 13'd3750, 13'd3700, 13'd3650, 13'd3600, 13'd3000, 13'd3000, 13'd3000
   };
   localparam logic [6:0] CURVE_PCT [CURVE_MAX] = '{
      7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70, 7'd60,
      7'd55, 7'd50, 7'd40, 7'd30, 7'd20, 7'd0, 7'd0, 7'd0
   };

   typedef struct packed {
      logic [6:0]  low_enter_pct;
      logic [6:0]  low_exit_pct;
      logic [6:0]  crit_enter_pct;
      logic [6:0]  crit_exit_pct;
      logic [12:0] charging_mv;
      logic [11:0] adc_ref_mv;
   } cfg_type;

   typedef struct packed {
      logic       acc;
      logic       clr;
      logic       div_start;
      logic [1:0] div_sel;
      logic       load_avg;
      logic       load_prod;
      logic       load_mv;
      logic       load_seg;
      logic       load_pct;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic div_done;
   } status_type;

endpackage
`default_nettype wire

// ----- src/bgh_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by the gauge datapath.
// Depends on bgh_pkg for operand widths.
`default_nettype none
module bgh_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [bgh_pkg::DIV_W-1:0]   dividend,
   input  wire logic [bgh_pkg::DEN_W-1:0]   divisor,
   output logic                             done,
   output logic [bgh_pkg::DIV_W-1:0]        quotient
);
   import bgh_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] dvd_ff, dvd_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   part;
   logic [DEN_W+1:0] trial;

   always_comb begin
      part    = {rem_ff, dvd_ff[DIV_W-1]};
      trial   = {1'b0, part} - {2'b00, den_ff};
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
         cnt_in  = CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DEN_W+1]) begin
            rem_in = trial[DEN_W-1:0];
            dvd_in = {dvd_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = part[DEN_W-1:0];
            dvd_in = {dvd_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule
`default_nettype wire

// ----- src/bgh_dp.sv -----
// Gauge datapath: sample accumulation, average and millivolt conversion, curve
// lookup, hysteresis level and result registers. Depends on bgh_pkg and bgh_div.
`default_nettype none
module bgh_dp #(
   parameter int SAMPLES      = 16,
   parameter int CURVE_POINTS = 14
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bgh_pkg::cmd_type      cmd,
   output bgh_pkg::status_type        status,
   input  wire bgh_pkg::cfg_type      cfg,
   input  wire logic [11:0]           raw_sample,
   input  wire logic                  sample_ok,
   output logic [12:0]                battery_mv,
   output logic [6:0]                 charge_percent,
   output logic [1:0]                 level_state,
   output logic                       state_changed
);
   import bgh_pkg::*;

   localparam int CURVE_LEN = (CURVE_POINTS < 2) ? 2 :
                              ((CURVE_POINTS > CURVE_MAX) ? CURVE_MAX : CURVE_POINTS);
   localparam logic [12:0] MV_LAST = CURVE_MV[CURVE_LEN-1];

   logic [15:0] sum_ff, sum_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [3:0]  idx_ff, idx_in;
   logic [1:0]  lvl_ff, lvl_in;
   logic [11:0] avg_ff;
   logic [23:0] prod_ff;
   logic [12:0] mv_ff;
   logic [19:0] num_ff;
   logic [12:0] den_ff;
   logic [6:0]  plo_ff;
   logic        full_ff;
   logic [6:0]  pct_ff;
   logic [12:0] out_mv_ff;
   logic [6:0]  out_pct_ff;
   logic [1:0]  out_lvl_ff;
   logic        out_chg_ff;

   logic             last;
   logic [4:0]       taken;
   logic [DIV_W-1:0] dvd;
   logic [DEN_W-1:0] dsr;
   logic             div_done;
   logic [DIV_W-1:0] quo;
   logic [12:0]      mv_fold;
   logic [11:0]      mv_quo;

   logic        found;
   logic [12:0] seg_vlo;
   logic [12:0] seg_den;
   logic [6:0]  seg_plo;
   logic [6:0]  seg_span;
   logic [12:0] seg_diff;
   logic [1:0]  lvl_next;

   assign taken = {1'b0, idx_ff} + 5'd1;
   assign last  = (taken == 5'(SAMPLES));

   // accumulator; window cleared once the average division has latched the sum
   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (cmd.clr) begin
         sum_in = '0;
         cnt_in = '0;
         idx_in = '0;
      end else if (cmd.acc) begin
         if (sample_ok) begin
            sum_in = sum_ff + {4'd0, raw_sample};
            cnt_in = cnt_ff + 5'd1;
         end
         idx_in = last ? 4'd0 : taken[3:0];
      end
   end

   // divider operands; an empty window has a zero sum, so divisor one gives zero
   always_comb begin
      case (cmd.div_sel)
         DSEL_AVG: begin
            dvd = {8'd0, sum_ff};
            dsr = (cnt_ff == 5'd0) ? 13'd1 : {8'd0, cnt_ff};
         end
         DSEL_PCT: begin
            dvd = {4'd0, num_ff};
            dsr = den_ff;
         end
         default: begin
            dvd = '0;
            dsr = 13'd1;
         end
      endcase
   end

   bgh_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd),
      .divisor  (dsr),
      .done     (div_done),
      .quotient (quo)
   );

   // x / 4095 with x = hi*4096 + lo = hi*4095 + (hi + lo); the product never
   // exceeds 4095*4095, so hi + lo stays below 2*4095 and one carry suffices
   assign mv_fold = {1'b0, prod_ff[23:12]} + {1'b0, prod_ff[11:0]};
   assign mv_quo  = prod_ff[23:12] + {11'd0, (mv_fold >= {1'b0, RAW_FULL})};

   // first curve segment that brackets the voltage
   always_comb begin
      found   = 1'b0;
      seg_vlo = '0;
      seg_den = 13'd1;
      seg_plo = '0;
      seg_span = '0;
      for (int i = 0; i < CURVE_MAX - 1; i++) begin
         if (!found && (i + 1 < CURVE_LEN) && (CURVE_MV[i] > CURVE_MV[i+1]) &&
             (mv_ff <= CURVE_MV[i]) && (mv_ff >= CURVE_MV[i+1])) begin
            found    = 1'b1;
            seg_vlo  = CURVE_MV[i+1];
            seg_den  = CURVE_MV[i] - CURVE_MV[i+1];
            seg_plo  = CURVE_PCT[i+1];
            seg_span = (CURVE_PCT[i] >= CURVE_PCT[i+1]) ?
                       (CURVE_PCT[i] - CURVE_PCT[i+1]) : 7'd0;
         end
      end
      seg_diff = mv_ff - seg_vlo;
   end

   always_comb begin
      if (mv_ff > cfg.charging_mv) begin
         lvl_next = LVL_CHARGING;
      end else if (lvl_ff == LVL_CRIT && pct_ff < cfg.crit_exit_pct) begin
         lvl_next = LVL_CRIT;
      end else if (lvl_ff == LVL_LOW && pct_ff <= cfg.crit_enter_pct) begin
         lvl_next = LVL_CRIT;
      end else if (lvl_ff == LVL_LOW && pct_ff < cfg.low_exit_pct) begin
         lvl_next = LVL_LOW;
      end else if (pct_ff <= cfg.crit_enter_pct) begin
         lvl_next = LVL_CRIT;
      end else if (pct_ff <= cfg.low_enter_pct) begin
         lvl_next = LVL_LOW;
      end else begin
         lvl_next = LVL_NORMAL;
      end
      lvl_in = cmd.load_out ? lvl_next : lvl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
         idx_ff <= '0;
         lvl_ff <= LVL_NORMAL;
      end else begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
         lvl_ff <= lvl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_avg) begin
         avg_ff <= (quo > {12'd0, RAW_FULL}) ? RAW_FULL : quo[11:0];
      end
      if (cmd.load_prod) begin
         prod_ff <= avg_ff * cfg.adc_ref_mv;
      end
      if (cmd.load_mv) begin
         mv_ff <= {mv_quo, 1'b0};
      end
      if (cmd.load_seg) begin
         full_ff <= (mv_ff >= CURVE_MV[0]);
         if (mv_ff >= CURVE_MV[0] || mv_ff <= MV_LAST || !found) begin
            num_ff <= '0;
            den_ff <= 13'd1;
            plo_ff <= '0;
         end else begin
            num_ff <= seg_diff * seg_span;
            den_ff <= seg_den;
            plo_ff <= seg_plo;
         end
      end
      if (cmd.load_pct) begin
         pct_ff <= full_ff ? CURVE_PCT[0] : (plo_ff + quo[6:0]);
      end
      if (cmd.load_out) begin
         out_mv_ff  <= mv_ff;
         out_pct_ff <= pct_ff;
         out_lvl_ff <= lvl_next;
         out_chg_ff <= (lvl_next != lvl_ff);
      end
   end

   assign status.last     = last;
   assign status.div_done = div_done;

   assign battery_mv     = out_mv_ff;
   assign charge_percent = out_pct_ff;
   assign level_state    = out_lvl_ff;
   assign state_changed  = out_chg_ff;

endmodule
`default_nettype wire

// ----- src/bgh_ctrl.sv -----
// Gauge controller: sequences the window close through the shared divider and
// owns both handshakes. Depends on bgh_pkg.
`default_nettype none
module bgh_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire bgh_pkg::status_type   status,
   output bgh_pkg::cmd_type           cmd
);
   import bgh_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_AVG_GO = 4'd1;
   localparam logic [3:0] S_AVG_W  = 4'd2;
   localparam logic [3:0] S_MUL    = 4'd3;
   localparam logic [3:0] S_MV     = 4'd4;
   localparam logic [3:0] S_SEG    = 4'd5;
   localparam logic [3:0] S_PCT_GO = 4'd6;
   localparam logic [3:0] S_PCT_W  = 4'd7;
   localparam logic [3:0] S_LVL    = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   // a window may only close once the previous result has gone
   assign req_stall = (state_ff != S_IDLE) || (status.last && rsp_valid_ff);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd          = '0;
      cmd.div_sel  = DSEL_AVG;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.acc = 1'b1;
               if (status.last) begin
                  state_in = S_AVG_GO;
               end
            end
         end
         S_AVG_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DSEL_AVG;
            cmd.clr       = 1'b1;
            state_in      = S_AVG_W;
         end
         S_AVG_W: begin
            if (status.div_done) begin
               cmd.load_avg = 1'b1;
               state_in     = S_MUL;
            end
         end
         S_MUL: begin
            cmd.load_prod = 1'b1;
            state_in      = S_MV;
         end
         S_MV: begin
            cmd.load_mv = 1'b1;
            state_in    = S_SEG;
         end
         S_SEG: begin
            cmd.load_seg = 1'b1;
            state_in     = S_PCT_GO;
         end
         S_PCT_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DSEL_PCT;
            state_in      = S_PCT_W;
         end
         S_PCT_W: begin
            if (status.div_done) begin
               cmd.load_pct = 1'b1;
               state_in     = S_LVL;
            end
         end
         S_LVL: begin
            cmd.load_out = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ----- src/battery_gauge_hysteresis.sv -----
// Battery gauge: averages SAMPLES readings, maps to mV and percent, tracks level.
// Samples are taken one per cycle while req_stall is low; the result follows the closing
// sample after two 24-step passes of the shared restoring divider plus sequencing, with
// the input stalled meanwhile.
// A closing sample waits while the previous result is still untaken.
// Synchronous active-high reset clears the window, sets level (normal) and config defaults.
// Depends on bgh_pkg, bgh_ctrl, bgh_dp, bgh_div.
`default_nettype none
module battery_gauge_hysteresis #(
   parameter int SAMPLES      = 16,
   parameter int CURVE_POINTS = 14
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [11:0] req_raw_sample,
   input  wire logic        req_sample_ok,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [12:0]      rsp_battery_mv,
   output logic [6:0]       rsp_charge_percent,
   output logic [1:0]       rsp_level_state,
   output logic             rsp_state_changed,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import bgh_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;
   logic       wr;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign wr      = psel && penable && pwrite;
   assign reg_idx = paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (reg_idx)
            REG_LOW_ENTER:  cfg_in.low_enter_pct  = pwdata[6:0];
            REG_LOW_EXIT:   cfg_in.low_exit_pct   = pwdata[6:0];
            REG_CRIT_ENTER: cfg_in.crit_enter_pct = pwdata[6:0];
            REG_CRIT_EXIT:  cfg_in.crit_exit_pct  = pwdata[6:0];
            REG_CHARGING:   cfg_in.charging_mv    = pwdata[12:0];
            REG_ADC_REF:    cfg_in.adc_ref_mv     = pwdata[11:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_LOW_ENTER:  prdata = {25'd0, cfg_ff.low_enter_pct};
         REG_LOW_EXIT:   prdata = {25'd0, cfg_ff.low_exit_pct};
         REG_CRIT_ENTER: prdata = {25'd0, cfg_ff.crit_enter_pct};
         REG_CRIT_EXIT:  prdata = {25'd0, cfg_ff.crit_exit_pct};
         REG_CHARGING:   prdata = {19'd0, cfg_ff.charging_mv};
         REG_ADC_REF:    prdata = {20'd0, cfg_ff.adc_ref_mv};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_enter_pct  <= 7'd10;
         cfg_ff.low_exit_pct   <= 7'd12;
         cfg_ff.crit_enter_pct <= 7'd5;
         cfg_ff.crit_exit_pct  <= 7'd7;
         cfg_ff.charging_mv    <= 13'd4150;
         cfg_ff.adc_ref_mv     <= 12'd3300;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bgh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bgh_dp #(
      .SAMPLES      (SAMPLES),
      .CURVE_POINTS (CURVE_POINTS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .cfg            (cfg_ff),
      .raw_sample     (req_raw_sample),
      .sample_ok      (req_sample_ok),
      .battery_mv     (rsp_battery_mv),
      .charge_percent (rsp_charge_percent),
      .level_state    (rsp_level_state),
      .state_changed  (rsp_state_changed)
   );

endmodule
`default_nettype wire

// ----- tb/sv/battery_gauge_hysteresis_tb.sv -----
// Self-checking testbench for battery_gauge_hysteresis: directed windows, then random phases.
// Holds its own gauge predictor (averaging, discharge curve, level hysteresis) and register copy.
// Depends on bgh_pkg and the battery_gauge_hysteresis top level.
`timescale 1ns / 100ps
module battery_gauge_hysteresis_tb;
   import bgh_pkg::*;

   localparam int SAMPLES      = 16;
   localparam int KNEES        = 14;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 120;
   localparam int DRAIN_CYCLES = 150;
   localparam int HOLD_CYCLES  = 400;
   localparam logic [2:0] REG_UNUSED = 3'd6;

   localparam int unsigned KNEE_MV [KNEES] = '{
      4200, 4150, 4100, 4050, 4000, 3950, 3900, 3850, 3800, 3750, 3700, 3650, 3600, 3000
   };
   localparam int unsigned KNEE_PCT [KNEES] = '{
      100, 95, 90, 85, 80, 75, 70, 60, 55, 50, 40, 30, 20, 0
   };

   typedef struct packed {
      logic [12:0] mv;
      logic [6:0]  pct;
      logic [1:0]  lvl;
      logic        chg;
   } gauge_reading_type;

   typedef struct packed {
      logic [11:0]       raw_a;    // even samples
      logic [11:0]       raw_b;    // odd samples
      logic [15:0]       ok_mask;
      logic              typed;
      gauge_reading_type want;
   } window_row_type;

   localparam int DIRECTED_ROWS = 14;
   localparam window_row_type DIRECTED_WINDOWS [DIRECTED_ROWS] = '{
      '{12'd0,    12'd0,    16'hFFFF, 1'b1, {13'd0,    7'd0,   LVL_CRIT,     1'b1}},
      '{12'd0,    12'd0,    16'h0000, 1'b1, {13'd0,    7'd0,   LVL_CRIT,     1'b0}},
      '{12'd4095, 12'd4095, 16'hFFFF, 1'b1, {13'd6600, 7'd100, LVL_CHARGING, 1'b1}},
      '{12'd2606, 12'd2606, 16'hFFFF, 1'b0, '0},
      '{12'd2575, 12'd2575, 16'hFFFF, 1'b0, '0},
      '{12'd1862, 12'd1862, 16'hFFFF, 1'b0, '0},
      '{12'd1974, 12'd1974, 16'hFFFF, 1'b0, '0},
      '{12'd1992, 12'd1992, 16'hFFFF, 1'b0, '0},
      '{12'd2067, 12'd2067, 16'hFFFF, 1'b0, '0},
      '{12'd2085, 12'd2085, 16'hFFFF, 1'b0, '0},
      '{12'd2067, 12'd2067, 16'hFFFF, 1'b0, '0},
      '{12'd1955, 12'd1955, 16'hFFFF, 1'b0, '0},
      '{12'd4095, 12'd0,    16'h5555, 1'b0, '0},
      '{12'd3000, 12'd4095, 16'h0001, 1'b0, '0}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [11:0] req_raw_sample;
   logic        req_sample_ok;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [12:0] rsp_battery_mv;
   logic [6:0]  rsp_charge_percent;
   logic [1:0]  rsp_level_state;
   logic        rsp_state_changed;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // predictor state and register copy
   cfg_type     gauge_cfg;
   logic [15:0] win_sum;
   logic [4:0]  win_valid;
   logic [3:0]  win_index;
   logic [1:0]  level_now;

   gauge_reading_type expected_readings[$];
   window_row_type    directed_wants[$];
   int                fail_count = 0;
   int                sender_idle_pct = 0;
   int                stall_pct = 0;
   int                pressure_req = 0;
   int                pressure_seen = 0;

   battery_gauge_hysteresis u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_raw_sample     (req_raw_sample),
      .req_sample_ok      (req_sample_ok),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_battery_mv     (rsp_battery_mv),
      .rsp_charge_percent (rsp_charge_percent),
      .rsp_level_state    (rsp_level_state),
      .rsp_state_changed  (rsp_state_changed),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always #5 clock = ~clock;

   function automatic int unsigned curve_percent(input int unsigned mv);
      int i;
      if (mv >= KNEE_MV[0]) return KNEE_PCT[0];
      if (mv <= KNEE_MV[KNEES-1]) return 0;
      for (i = 0; i < KNEES - 1; i++) begin
         if (mv <= KNEE_MV[i] && mv >= KNEE_MV[i+1])
            return KNEE_PCT[i+1] + (mv - KNEE_MV[i+1]) * (KNEE_PCT[i] - KNEE_PCT[i+1])
                   / (KNEE_MV[i] - KNEE_MV[i+1]);
      end
      return 0;
   endfunction

   function automatic logic [1:0] next_level(input int unsigned mv, input int unsigned pct,
                                             input logic [1:0] prev);
      if (mv > gauge_cfg.charging_mv) return LVL_CHARGING;
      if (prev == LVL_CRIT) begin
         if (pct < gauge_cfg.crit_exit_pct) return LVL_CRIT;
      end else if (prev == LVL_LOW) begin
         if (pct <= gauge_cfg.crit_enter_pct) return LVL_CRIT;
         if (pct < gauge_cfg.low_exit_pct) return LVL_LOW;
      end
      if (pct <= gauge_cfg.crit_enter_pct) return LVL_CRIT;
      if (pct <= gauge_cfg.low_enter_pct) return LVL_LOW;
      return LVL_NORMAL;
   endfunction

   // Folds one sample into the window; returns 1 with the reading when the window closes.
   function automatic bit gauge_predict_sample(input logic [11:0] raw, input logic ok,
                                               output gauge_reading_type res);
      int unsigned avg;
      int unsigned mv;
      int unsigned pct;
      logic [1:0]  lvl;
      res = '0;
      if (ok) begin
         win_sum   = win_sum + raw;
         win_valid = win_valid + 5'd1;
      end
      if (int'(win_index) + 1 < SAMPLES) begin
         win_index = win_index + 4'd1;
         return 1'b0;
      end
      mv = 0;
      if (win_valid != 0) begin
         avg = win_sum / win_valid;
         if (avg > 4095) avg = 4095;
         mv = (avg * gauge_cfg.adc_ref_mv) / 4095 * 2;
      end
      pct = curve_percent(mv);
      lvl = next_level(mv, pct, level_now);
      res = '{mv: 13'(mv), pct: 7'(pct), lvl: lvl, chg: (lvl != level_now)};
      level_now = lvl;
      win_sum   = '0;
      win_valid = '0;
      win_index = '0;
      return 1'b1;
   endfunction

   function automatic logic [31:0] reg_image(input logic [2:0] idx);
      case (idx)
         REG_LOW_ENTER:  return 32'(gauge_cfg.low_enter_pct);
         REG_LOW_EXIT:   return 32'(gauge_cfg.low_exit_pct);
         REG_CRIT_ENTER: return 32'(gauge_cfg.crit_enter_pct);
         REG_CRIT_EXIT:  return 32'(gauge_cfg.crit_exit_pct);
         REG_CHARGING:   return 32'(gauge_cfg.charging_mv);
         REG_ADC_REF:    return 32'(gauge_cfg.adc_ref_mv);
         default:        return '0;
      endcase
   endfunction

   // sample requests in, readings out
   always @(posedge clock) begin : monitor
      gauge_reading_type want;
      gauge_reading_type got;
      window_row_type    row;
      if (reset === 1'b0) begin
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            if (gauge_predict_sample(req_raw_sample, req_sample_ok, want)) begin
               if (directed_wants.size() != 0) begin
                  row = directed_wants.pop_front();
                  if (row.typed) want = row.want;
               end
               expected_readings.push_back(want);
            end
         end
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got = '{mv: rsp_battery_mv, pct: rsp_charge_percent, lvl: rsp_level_state,
                    chg: rsp_state_changed};
            if (expected_readings.size() == 0) begin
               $error("reading with none expected: battery_mv %0d", got.mv);
               fail_count++;
            end else begin
               want = expected_readings.pop_front();
               if (got.mv !== want.mv) begin
                  $error("battery_mv: expected %0d, got %0d", want.mv, got.mv);
                  fail_count++;
               end
               if (got.pct !== want.pct) begin
                  $error("charge_percent: expected %0d, got %0d", want.pct, got.pct);
                  fail_count++;
               end
               if (got.lvl !== want.lvl) begin
                  $error("level_state: expected %0d, got %0d", want.lvl, got.lvl);
                  fail_count++;
               end
               if (got.chg !== want.chg) begin
                  $error("state_changed: expected %0d, got %0d", want.chg, got.chg);
                  fail_count++;
               end
            end
         end
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (pressure_seen != pressure_req) begin
            pressure_seen = pressure_req;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   task automatic send_sample(input logic [11:0] raw, input logic ok);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_raw_sample <= raw;
      req_sample_ok  <= ok;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic drain_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic reg_write(input logic [2:0] idx, input logic [31:0] word);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= word;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_LOW_ENTER:  gauge_cfg.low_enter_pct  = word[6:0];
         REG_LOW_EXIT:   gauge_cfg.low_exit_pct   = word[6:0];
         REG_CRIT_ENTER: gauge_cfg.crit_enter_pct = word[6:0];
         REG_CRIT_EXIT:  gauge_cfg.crit_exit_pct  = word[6:0];
         REG_CHARGING:   gauge_cfg.charging_mv    = word[12:0];
         REG_ADC_REF:    gauge_cfg.adc_ref_mv     = word[11:0];
         default:        ;
      endcase
   endtask

   task automatic reg_check(input logic [2:0] idx);
      logic [31:0] data;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      data = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (data !== reg_image(idx)) begin
         $error("register %0d: expected %0d, got %0d", idx, reg_image(idx), data);
         fail_count++;
      end
   endtask

   task automatic set_thresholds(input int le, input int lx, input int ce, input int cx,
                                 input int chg_mv, input int ref_mv, input bit junk);
      logic [31:0] hi;
      int i;
      hi = junk ? ($urandom() << 13) : 32'd0;   // upper bits must be dropped
      reg_write(REG_LOW_ENTER,  hi | 32'(le));
      reg_write(REG_LOW_EXIT,   hi | 32'(lx));
      reg_write(REG_CRIT_ENTER, hi | 32'(ce));
      reg_write(REG_CRIT_EXIT,  hi | 32'(cx));
      reg_write(REG_CHARGING,   hi | 32'(chg_mv));
      reg_write(REG_ADC_REF,    (hi << 1) | 32'(ref_mv));
      for (i = int'(REG_LOW_ENTER); i <= int'(REG_ADC_REF); i++) reg_check(3'(i));
   endtask

   initial begin : stimulus
      int          r;
      int          s;
      int          p;
      int          k;
      int          le;
      int          ce;
      int          gen_pos;
      int          win_kind;
      int          walk_mv;
      int          centre;
      int          raw_i;
      logic [11:0] raw;
      logic        ok;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_raw_sample = '0;
      req_sample_ok  = 1'b0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      gauge_cfg      = '{low_enter_pct: 7'd10, low_exit_pct: 7'd12, crit_enter_pct: 7'd5,
                         crit_exit_pct: 7'd7, charging_mv: 13'd4150, adc_ref_mv: 12'd3300};
      win_sum        = '0;
      win_valid      = '0;
      win_index      = '0;
      level_now      = LVL_NORMAL;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed windows at reset settings
      for (r = 0; r < DIRECTED_ROWS; r++) begin
         directed_wants.push_back(DIRECTED_WINDOWS[r]);
         for (s = 0; s < SAMPLES; s++)
            send_sample(s[0] ? DIRECTED_WINDOWS[r].raw_b : DIRECTED_WINDOWS[r].raw_a,
                        DIRECTED_WINDOWS[r].ok_mask[s]);
      end

      gen_pos  = 0;
      win_kind = 0;
      walk_mv  = 3300;
      centre   = 0;
      for (p = 0; p < PHASES; p++) begin
         drain_block();
         case (p)
            0: begin
               // write to an unmapped slot must leave every register alone
               reg_write(REG_UNUSED, 32'hFFFF_FFFF);
               for (k = int'(REG_LOW_ENTER); k <= int'(REG_ADC_REF); k++) reg_check(3'(k));
            end
            1: set_thresholds(0, 0, 0, 0, 0, 0, 1'b0);
            2: set_thresholds(127, 127, 127, 127, 8191, 4095, 1'b0);
            3: set_thresholds(3, 2, 20, 1, 3500, 3300, 1'b1);
            4: set_thresholds(40, 45, 20, 25, 4150, 3300, 1'b0);
            default: begin
               le = $urandom_range(0, 30);
               ce = $urandom_range(0, le);
               set_thresholds(le, le + $urandom_range(0, 6), ce, ce + $urandom_range(0, 4),
                              $urandom_range(3600, 8191), $urandom_range(2000, 4095), 1'b1);
            end
         endcase
         case (p % 4)
            1: begin sender_idle_pct = 69; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 69; end
            3: begin sender_idle_pct = 6;  stall_pct = 6;  end
            default: begin sender_idle_pct = 0; stall_pct = 0; end
         endcase
         if (p == 4) pressure_req++;

         for (k = 0; k < PHASE_ITEMS; k++) begin
            if (gen_pos == 0) begin
               // battery voltage wanders through the low end of the curve, with jumps
               win_kind = $urandom_range(0, 99);
               walk_mv  = walk_mv + $urandom_range(0, 120) - 60;
               if ($urandom_range(0, 99) < 5) walk_mv = $urandom_range(0, 8190);
               if (walk_mv < 2900 && walk_mv > 2000) walk_mv = 2900;
               if (walk_mv > 4300 && walk_mv < 6000) walk_mv = 4300;
               if (gauge_cfg.adc_ref_mv == 0) centre = $urandom_range(0, 4095);
               else centre = walk_mv * 4095 / (2 * gauge_cfg.adc_ref_mv);
               if (centre > 4095) centre = 4095;
            end
            raw_i = centre + $urandom_range(0, 8) - 4;
            ok    = 1'b1;
            if (win_kind >= 95) begin
               raw_i = $urandom_range(0, 4095);
               ok    = 1'b0;
            end else if (win_kind >= 80) begin
               if ($urandom_range(0, 99) < 10) raw_i = $urandom_range(0, 4095);
               ok = ($urandom_range(0, 99) < 75);
            end
            if (raw_i < 0) raw_i = 0;
            if (raw_i > 4095) raw_i = 4095;
            raw = 12'(raw_i);
            send_sample(raw, ok);
            gen_pos = (gen_pos + 1) % SAMPLES;
         end
      end

      drain_block();
      if (fail_count == 0 && expected_readings.size() == 0) begin
         $display("battery_gauge_hysteresis_tb passed");
      end else begin
         $display("battery_gauge_hysteresis_tb failed");
      end
      $finish;
   end

   initial begin : watchdog
      #5000000;
      $display("battery_gauge_hysteresis_tb failed");
      $finish;
   end

endmodule

// ----- files.f -----
src/bgh_pkg.sv
src/bgh_div.sv
src/bgh_dp.sv
src/bgh_ctrl.sv
src/battery_gauge_hysteresis.sv
tb/sv/battery_gauge_hysteresis_tb.sv
